/* hw/rtl/ufs_pkg.sv */
// Package for the URI field splitter: the classified byte item, back-end status,
// the scheme name table and character constants.
// Used by ufs_front, ufs_fifo, ufs_back and uri_field_splitter.
package ufs_pkg;

	localparam int MAX_LEN_DEF    = 1024;
	localparam int FIFO_DEPTH_DEF = 4;
	localparam int NUM_NAMES      = 9;
	localparam int OFF_W          = 10;
	localparam int PORT_W         = 16;
	localparam int SCHEME_W       = 4;
	localparam int RES_W          = 56;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DIGIT0 = 8'h30;
	localparam logic [7:0] CH_DIGIT9 = 8'h39;
	localparam logic [7:0] CH_LOWER = 8'h20;
	localparam logic [PORT_W-1:0] PORT_MAX = 16'hFFFF;

	// One input byte after classification in the front end.
	typedef struct packed {
		logic [7:0] ch;
		logic       has_byte;
		logic       last;
		logic       is_zero;
		logic       is_colon;
		logic       is_slash;
		logic       is_digit;
		logic [3:0] digit;
	} ufs_item_t;

	// Back-end status, watched by the top level.
	typedef struct packed {
		logic pop_last;
		logic s2_valid;
	} ufs_back_stat_t;

	// Length of scheme name k (gopher, finger, gemini, https, http, file, about, ssh, ftp).
	function automatic logic [2:0] name_len(input int k);
		logic [2:0] len;
		case (k)
			0, 1, 2: len = 3'd6;
			3, 6:    len = 3'd5;
			4, 5:    len = 3'd4;
			default: len = 3'd3;
		endcase
		return len;
	endfunction

	// Lowercase character i of scheme name k; zero past the end of the name.
	function automatic logic [7:0] name_char(input int k, input logic [2:0] i);
		logic [47:0] txt;
		logic [7:0]  c;
		case (k)
			0:       txt = "gopher";
			1:       txt = "finger";
			2:       txt = "gemini";
			3:       txt = {8'h00, "https"};
			4:       txt = {16'h0000, "http"};
			5:       txt = {16'h0000, "file"};
			6:       txt = {8'h00, "about"};
			7:       txt = {24'h000000, "ssh"};
			default: txt = {24'h000000, "ftp"};
		endcase
		// The string's first character sits in the highest used byte.
		if (i < name_len(k)) begin
			c = txt[8*(32'(name_len(k)) - 1 - 32'(i)) +: 8];
		end else begin
			c = 8'h00;
		end
		return c;
	endfunction

endpackage

/* hw/rtl/ufs_front.sv */
// Front end of the URI field splitter: accepts stream transfers and classifies
// each byte into a ufs_pkg::ufs_item_t held in one register stage.
// Depends on ufs_pkg.
module ufs_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,  // [7:0] ch
	input  logic               s_axis_tuser,  // [0] has_byte
	input  logic               s_axis_tlast,
	output logic               out_valid,
	input  logic               out_ready,
	output ufs_pkg::ufs_item_t out_item
);

	logic               valid_s1;
	ufs_pkg::ufs_item_t item_s1;
	ufs_pkg::ufs_item_t cls;

	always_comb begin
		cls.ch       = s_axis_tdata;
		cls.has_byte = s_axis_tuser;
		cls.last     = s_axis_tlast;
		cls.is_zero  = (s_axis_tdata == 8'h00);
		cls.is_colon = (s_axis_tdata == ufs_pkg::CH_COLON);
		cls.is_slash = (s_axis_tdata == ufs_pkg::CH_SLASH);
		cls.is_digit = (s_axis_tdata >= ufs_pkg::CH_DIGIT0) &&
			(s_axis_tdata <= ufs_pkg::CH_DIGIT9);
		cls.digit    = 4'(s_axis_tdata - ufs_pkg::CH_DIGIT0);
	end

	assign s_axis_tready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= cls;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

endmodule

/* hw/rtl/ufs_fifo.sv */
// Short queue of classified bytes between the front and back ends of the
// URI field splitter. Depends on ufs_pkg.
module ufs_fifo #(
	parameter int DEPTH = ufs_pkg::FIFO_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ufs_pkg::ufs_item_t in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output ufs_pkg::ufs_item_t out_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ufs_pkg::ufs_item_t mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push;
	logic               pop;

	assign in_ready  = (count_q != CNT_W'(DEPTH));
	assign out_valid = (count_q != '0);
	assign out_item  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

endmodule

/* hw/rtl/ufs_back.sv */
// Back end of the URI field splitter: parses the byte stream, snapshots the
// string state on the last byte and builds the packed result.
// Depends on ufs_pkg.
module ufs_back #(
	parameter int MAX_LEN = ufs_pkg::MAX_LEN_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  ufs_pkg::ufs_item_t        in_item,
	output logic                      m_valid,
	input  logic                      m_ready,
	output logic [ufs_pkg::RES_W-1:0] m_data,
	output ufs_pkg::ufs_back_stat_t   stat
);

	localparam int POS_W = $clog2(MAX_LEN);
	localparam logic [POS_W-1:0] LEN_LIMIT = POS_W'(MAX_LEN - 1);
	localparam int NN = ufs_pkg::NUM_NAMES;
	localparam int PW = ufs_pkg::PORT_W;

	// Live string state. Tracker 0 counts from offset 0, tracker 1 from after "://".
	logic [POS_W-1:0] pos_q;
	logic [15:0]      recent_q;
	logic             sep_q;
	logic [POS_W-1:0] soff_q;
	logic [NN-1:0]    kw_q;
	logic             term_q;
	logic             long_q;
	logic [1:0]       hv_q;
	logic [POS_W-1:0] he_q [2];
	logic [1:0]       col_q;
	logic [1:0]       done_q;
	logic [PW-1:0]    port_q [2];
	logic [1:0]       sv_q;
	logic [POS_W-1:0] sl_q [2];

	logic [POS_W-1:0] n_pos;
	logic [15:0]      n_recent;
	logic             n_sep;
	logic [POS_W-1:0] n_soff;
	logic [NN-1:0]    n_kw;
	logic             n_term;
	logic             n_long;
	logic [1:0]       n_hv;
	logic [POS_W-1:0] n_he [2];
	logic [1:0]       n_col;
	logic [1:0]       n_done;
	logic [PW-1:0]    n_port [2];
	logic [1:0]       n_sv;
	logic [POS_W-1:0] n_sl [2];

	// Snapshot of one finished string.
	logic             v_s2;
	logic             sep_s2;
	logic [POS_W-1:0] soff_s2;
	logic [NN-1:0]    kw_s2;
	logic [POS_W-1:0] pos_s2;
	logic             long_s2;
	logic             hv_s2;
	logic [POS_W-1:0] he_s2;
	logic             col_s2;
	logic [PW-1:0]    port_s2;
	logic             sv_s2;
	logic [POS_W-1:0] sl_s2;

	logic                      m_valid_q;
	logic [ufs_pkg::RES_W-1:0] m_data_q;

	logic s2_adv;
	logic s2_free;
	logic pop;
	logic pop_last;

	assign s2_adv   = v_s2 && (!m_valid_q || m_ready);
	assign s2_free  = !v_s2 || s2_adv;
	assign in_ready = !in_item.last || s2_free;
	assign pop      = in_valid && in_ready;
	assign pop_last = pop && in_item.last;

	// Effect of one byte on the live state.
	always_comb begin
		logic [7:0]       lc;
		logic [19:0]      pv;
		logic [POS_W-1:0] idx;
		n_pos    = pos_q;
		n_recent = recent_q;
		n_sep    = sep_q;
		n_soff   = soff_q;
		n_kw     = kw_q;
		n_term   = term_q;
		n_long   = long_q;
		n_hv     = hv_q;
		n_col    = col_q;
		n_done   = done_q;
		n_sv     = sv_q;
		for (int t = 0; t < 2; t++) begin
			n_he[t]   = he_q[t];
			n_port[t] = port_q[t];
			n_sl[t]   = sl_q[t];
		end
		lc  = in_item.ch | ufs_pkg::CH_LOWER;
		idx = pos_q;
		pv  = '0;
		if (pop && in_item.has_byte && !term_q) begin
			if (in_item.is_zero) begin
				n_term = 1'b1;
			end else if (pos_q >= LEN_LIMIT) begin
				n_long = 1'b1;
			end else begin
				for (int k = 0; k < NN; k++) begin
					if (idx < POS_W'(ufs_pkg::name_len(k)) &&
						lc != ufs_pkg::name_char(k, idx[2:0])) begin
						n_kw[k] = 1'b0;
					end
				end
				if (!sep_q && in_item.is_slash &&
					recent_q == {ufs_pkg::CH_COLON, ufs_pkg::CH_SLASH} &&
					idx >= POS_W'(2)) begin
					n_sep  = 1'b1;
					n_soff = idx - POS_W'(2);
				end
				// The after-separator tracker only sees bytes past a separator found earlier.
				for (int t = 0; t < 2; t++) begin
					if (t == 0 || sep_q) begin
						if (!hv_q[t] && (in_item.is_colon || in_item.is_slash)) begin
							n_hv[t] = 1'b1;
							n_he[t] = idx;
						end
						if (!sv_q[t] && in_item.is_slash) begin
							n_sv[t] = 1'b1;
							n_sl[t] = idx;
						end
						if (!col_q[t]) begin
							if (in_item.is_colon) begin
								n_col[t] = 1'b1;
							end
						end else if (!done_q[t]) begin
							if (in_item.is_digit) begin
								pv = {port_q[t], 3'b000} + {3'b000, port_q[t], 1'b0} +
									20'(in_item.digit);
								n_port[t] = (pv > 20'(ufs_pkg::PORT_MAX)) ?
									ufs_pkg::PORT_MAX : pv[PW-1:0];
							end else begin
								n_done[t] = 1'b1;
							end
						end
					end
				end
				n_recent = {recent_q[7:0], in_item.ch};
				n_pos    = idx + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			recent_q <= '0;
			sep_q    <= 1'b0;
			soff_q   <= '0;
			kw_q     <= '1;
			term_q   <= 1'b0;
			long_q   <= 1'b0;
			hv_q     <= '0;
			col_q    <= '0;
			done_q   <= '0;
			sv_q     <= '0;
			for (int t = 0; t < 2; t++) begin
				he_q[t]   <= '0;
				port_q[t] <= '0;
				sl_q[t]   <= '0;
			end
		end else if (pop_last) begin
			pos_q    <= '0;
			recent_q <= '0;
			sep_q    <= 1'b0;
			soff_q   <= '0;
			kw_q     <= '1;
			term_q   <= 1'b0;
			long_q   <= 1'b0;
			hv_q     <= '0;
			col_q    <= '0;
			done_q   <= '0;
			sv_q     <= '0;
			for (int t = 0; t < 2; t++) begin
				he_q[t]   <= '0;
				port_q[t] <= '0;
				sl_q[t]   <= '0;
			end
		end else begin
			pos_q    <= n_pos;
			recent_q <= n_recent;
			sep_q    <= n_sep;
			soff_q   <= n_soff;
			kw_q     <= n_kw;
			term_q   <= n_term;
			long_q   <= n_long;
			hv_q     <= n_hv;
			col_q    <= n_col;
			done_q   <= n_done;
			sv_q     <= n_sv;
			for (int t = 0; t < 2; t++) begin
				he_q[t]   <= n_he[t];
				port_q[t] <= n_port[t];
				sl_q[t]   <= n_sl[t];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= pop_last;
		end
	end

	// The snapshot keeps only the tracker that the result will use.
	always_ff @(posedge clk) begin
		if (pop_last) begin
			sep_s2  <= n_sep;
			soff_s2 <= n_soff;
			kw_s2   <= n_kw;
			pos_s2  <= n_pos;
			long_s2 <= n_long;
			hv_s2   <= n_sep ? n_hv[1] : n_hv[0];
			he_s2   <= n_sep ? n_he[1] : n_he[0];
			col_s2  <= n_sep ? n_col[1] : n_col[0];
			port_s2 <= n_sep ? n_port[1] : n_port[0];
			sv_s2   <= n_sep ? n_sv[1] : n_sv[0];
			sl_s2   <= n_sep ? n_sl[1] : n_sl[0];
		end
	end

	// Result fields from the snapshot.
	logic [POS_W:0]                  beg;
	logic [POS_W:0]                  hlen;
	logic [ufs_pkg::SCHEME_W-1:0]    scheme;
	logic [ufs_pkg::RES_W-1:0]       res;

	always_comb begin
		beg  = sep_s2 ? ({1'b0, soff_s2} + (POS_W+1)'(3)) : '0;
		hlen = hv_s2 ? ({1'b0, he_s2} - beg) : ({1'b0, pos_s2} - beg);
		scheme = '0;
		// Walk downward so the first name in table order wins.
		for (int k = NN - 1; k >= 0; k--) begin
			if (sep_s2 && soff_s2 != '0 && soff_s2 == POS_W'(ufs_pkg::name_len(k)) &&
				kw_s2[k]) begin
				scheme = ufs_pkg::SCHEME_W'(k + 1);
			end
		end
		res        = '0;
		res[3:0]   = scheme;
		res[4]     = sep_s2;
		res[14:5]  = ufs_pkg::OFF_W'(beg);
		res[24:15] = ufs_pkg::OFF_W'(hlen);
		res[40:25] = col_s2 ? port_s2 : '0;
		res[41]    = sv_s2;
		res[51:42] = sv_s2 ? ufs_pkg::OFF_W'(sl_s2) : '0;
		res[52]    = long_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (!m_valid_q || m_ready) begin
			m_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			m_data_q <= res;
		end
	end

	assign m_valid = m_valid_q;
	assign m_data  = m_data_q;

	assign stat.pop_last = pop_last;
	assign stat.s2_valid = v_s2;

endmodule

/* hw/rtl/uri_field_splitter.sv */
// Top level of the URI field splitter: front end, byte queue and back end.
// Depends on ufs_pkg, ufs_front, ufs_fifo and ufs_back.
//
// Channel   Direction  Payload
// s_axis    in         tdata[7:0] ch, tuser has_byte, tlast last
// m_axis    out        tdata scheme/absolute/host/port/path/too_long, one per string
//
// One byte is accepted per cycle while s_axis_tready is high; each byte updates the parser
// state as the back end takes it, and the classify register plus queue keep both sides moving.
// A result passes the classify register, queue, snapshot stage and output register after
// its last byte is accepted; when nothing stalls, a new string may start on the next cycle.
// Reset clears all control and parser state at once; there is no clearing pass.
// While the output register stalls, one more result waits in the snapshot stage;
// only then is the last byte of a further string held back, and the queue and the
// classify register take FIFO_DEPTH further bytes before s_axis_tready drops.
module uri_field_splitter #(
	parameter int MAX_LEN    = ufs_pkg::MAX_LEN_DEF,
	parameter int FIFO_DEPTH = ufs_pkg::FIFO_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [7:0]                s_axis_tdata,  // [7:0] ch
	input  logic                      s_axis_tuser,  // [0] has_byte
	input  logic                      s_axis_tlast,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// [3:0] scheme_code, [4] is_absolute, [14:5] host_start, [24:15] host_length,
	// [40:25] port_value, [41] has_path, [51:42] path_start, [52] too_long
	output logic [ufs_pkg::RES_W-1:0] m_axis_tdata
);

	logic                    fr_valid;
	logic                    fr_ready;
	ufs_pkg::ufs_item_t      fr_item;
	logic                    q_valid;
	logic                    q_ready;
	ufs_pkg::ufs_item_t      q_item;
	ufs_pkg::ufs_back_stat_t stat;

	ufs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.out_valid     (fr_valid),
		.out_ready     (fr_ready),
		.out_item      (fr_item)
	);

	ufs_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_item   (fr_item),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_item  (q_item)
	);

	ufs_back #(
		.MAX_LEN (MAX_LEN)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_valid),
		.in_ready (q_ready),
		.in_item  (q_item),
		.m_valid  (m_axis_tvalid),
		.m_ready  (m_axis_tready),
		.m_data   (m_axis_tdata),
		.stat     (stat)
	);

	// A classified byte waiting on a full queue must not change.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fr_valid && !fr_ready) |=> (fr_valid && $stable(fr_item)))
		else $error("front stage lost or changed a byte while the queue was full");

	// Taking the last byte of a string always fills the snapshot stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		stat.pop_last |=> stat.s2_valid)
		else $error("last byte taken but no snapshot was stored");

	// A new result only appears after a snapshot was waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(stat.s2_valid))
		else $error("result appeared without a finished string");

endmodule
